// ----- rtl/c_style_lexical_tokenizer_assert.svh -----
// assertion macros shared by the tokenizer rtl
// expects signals named clk and rst_n in the including module
`ifndef C_STYLE_LEXICAL_TOKENIZER_ASSERT_SVH
`define C_STYLE_LEXICAL_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSLT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, checked outside reset
`define CSLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ----- rtl/cslt_pkg.sv -----
// types, constants and character-class helpers for the tokenizer
// no dependencies
`timescale 1ns / 1ps

package cslt_pkg;

    localparam int CSLT_TOKEN_LIMIT = 64;
    localparam int LEN_W            = 7;
    localparam int POS_W            = 16;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_CONST,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR
    } cslt_mode_t;

    typedef enum logic [1:0] {
        KIND_IDENT,
        KIND_CONST,
        KIND_OPER
    } cslt_kind_t;

    typedef struct packed {
        cslt_kind_t         kind;
        logic [LEN_W-1:0]   length;
        logic               overflow;
        logic [POS_W-1:0]   start;
        logic [7:0]         opch;
        logic               last;
    } cslt_result_t;

    // up to two results written into the queue in the same cycle
    typedef struct packed {
        logic [1:0]   count;
        cslt_result_t slot0;
        cslt_result_t slot1;
    } cslt_push_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_oper(input logic [7:0] b);
        return (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) || (b == CH_SLASH) ||
               (b == CH_EQ) || (b == CH_LT) || (b == CH_GT) || (b == CH_PCT);
    endfunction

endpackage

// ----- rtl/cslt_lexer.sv -----
// input register and lexer state machine; forms up to two results per beat
// depends on cslt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "c_style_lexical_tokenizer_assert.svh"

module cslt_lexer
    import cslt_pkg::*;
#(
    parameter int TOKEN_LIMIT = CSLT_TOKEN_LIMIT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  logic       room,
    output cslt_push_t push
);

    localparam int CAP_INT = (TOKEN_LIMIT > 127) ? 127 : ((TOKEN_LIMIT < 1) ? 1 : TOKEN_LIMIT);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(CAP_INT);

    logic             stage_valid_reg;
    logic [7:0]       byte_reg;
    logic             eot_reg;
    logic             fire;

    cslt_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic             run_ovf_reg, run_ovf_next;
    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;

    logic             flush_hit;
    logic             op_hit;
    logic             go_idle;
    cslt_result_t     flush_res;
    cslt_result_t     op_res;

    assign fire     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            run_len_reg   <= '0;
            run_ovf_reg   <= 1'b0;
            run_start_reg <= '0;
            byte_pos_reg  <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_len_reg   <= run_len_next;
            run_ovf_reg   <= run_ovf_next;
            run_start_reg <= run_start_next;
            byte_pos_reg  <= byte_pos_next;
        end
    end

    // token that is open before this byte, as it would be reported
    always_comb
    begin
        flush_res          = '0;
        flush_res.start    = run_start_reg;
        flush_res.length   = run_len_reg;
        flush_res.overflow = run_ovf_reg;
        flush_res.kind     = KIND_IDENT;
        if (mode_reg == MODE_CONST)
        begin
            flush_res.kind = KIND_CONST;
        end
        else if (mode_reg == MODE_SLASH)
        begin
            flush_res.kind     = KIND_OPER;
            flush_res.length   = LEN_W'(1);
            flush_res.overflow = 1'b0;
            flush_res.opch     = CH_SLASH;
        end
        op_res          = '0;
        op_res.kind     = KIND_OPER;
        op_res.length   = LEN_W'(1);
        op_res.start    = byte_pos_reg;
        op_res.opch     = byte_reg;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        run_len_next   = run_len_reg;
        run_ovf_next   = run_ovf_reg;
        run_start_next = run_start_reg;
        byte_pos_next  = byte_pos_reg;
        flush_hit      = 1'b0;
        op_hit         = 1'b0;
        go_idle        = 1'b0;
        if (fire)
        begin
            if (eot_reg)
            begin
                flush_hit = (mode_reg == MODE_IDENT) || (mode_reg == MODE_CONST) ||
                            (mode_reg == MODE_SLASH);
                mode_next      = MODE_IDLE;
                run_len_next   = '0;
                run_ovf_next   = 1'b0;
                run_start_next = '0;
                byte_pos_next  = '0;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + POS_W'(1);
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_letter(byte_reg) || is_digit(byte_reg) || (byte_reg == CH_UNDER))
                        begin
                            if (run_len_reg < CAP)
                                run_len_next = run_len_reg + LEN_W'(1);
                            else
                                run_ovf_next = 1'b1;
                        end
                        else
                        begin
                            flush_hit = 1'b1;
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_CONST:
                    begin
                        if (is_digit(byte_reg))
                        begin
                            if (run_len_reg < CAP)
                                run_len_next = run_len_reg + LEN_W'(1);
                            else
                                run_ovf_next = 1'b1;
                        end
                        else
                        begin
                            flush_hit = 1'b1;
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_SLASH:
                    begin
                        priority if (byte_reg == CH_SLASH)
                            mode_next = MODE_LINE;
                        else if (byte_reg == CH_STAR)
                            mode_next = MODE_BLOCK;
                        else
                        begin
                            flush_hit = 1'b1;
                            go_idle   = 1'b1;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (byte_reg == CH_LF)
                            mode_next = MODE_IDLE;
                    end
                    MODE_BLOCK:
                    begin
                        if (byte_reg == CH_STAR)
                            mode_next = MODE_BSTAR;
                    end
                    MODE_BSTAR:
                    begin
                        priority if (byte_reg == CH_SLASH)
                            mode_next = MODE_IDLE;
                        else if (byte_reg != CH_STAR)
                            mode_next = MODE_BLOCK;
                    end
                    default:
                    begin
                        go_idle = 1'b1;
                    end
                endcase
                if (go_idle)
                begin
                    mode_next = MODE_IDLE;
                    priority if (byte_reg == CH_SLASH)
                    begin
                        mode_next      = MODE_SLASH;
                        run_start_next = byte_pos_reg;
                    end
                    else if (is_letter(byte_reg) || (byte_reg == CH_UNDER))
                    begin
                        mode_next      = MODE_IDENT;
                        run_len_next   = LEN_W'(1);
                        run_ovf_next   = 1'b0;
                        run_start_next = byte_pos_reg;
                    end
                    else if (is_digit(byte_reg))
                    begin
                        mode_next      = MODE_CONST;
                        run_len_next   = LEN_W'(1);
                        run_ovf_next   = 1'b0;
                        run_start_next = byte_pos_reg;
                    end
                    else if (is_oper(byte_reg))
                    begin
                        op_hit = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        push.count      = 2'({1'b0, flush_hit} + {1'b0, op_hit});
        push.slot0      = flush_hit ? flush_res : op_res;
        push.slot0.last = !(flush_hit && op_hit);
        push.slot1      = op_res;
        push.slot1.last = 1'b1;
    end

    `CSLT_ASSERT_IMPLY(a_run_len_in_range,
        (mode_reg == MODE_IDENT) || (mode_reg == MODE_CONST),
        (run_len_reg != '0) && (run_len_reg <= CAP))
    `CSLT_ASSERT_IMPLY(a_ovf_only_at_cap,
        run_ovf_reg && ((mode_reg == MODE_IDENT) || (mode_reg == MODE_CONST)),
        run_len_reg == CAP)
    `CSLT_ASSERT_IMPLY(a_pair_ends_with_oper,
        push.count == 2'd2,
        (push.slot1.kind == KIND_OPER) && !push.slot0.last)
    `CSLT_ASSERT_NEXT(a_eot_restarts_offset,
        fire && eot_reg,
        (byte_pos_reg == '0) && (mode_reg == MODE_IDLE))

endmodule

// ----- rtl/cslt_result_fifo.sv -----
// small result queue: up to two writes and one read per cycle
// depends on cslt_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "c_style_lexical_tokenizer_assert.svh"

module cslt_result_fifo
    import cslt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cslt_push_t   push,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output cslt_result_t head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cslt_result_t     mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.slot1;
        end
    end

    `CSLT_ASSERT_IMPLY(a_count_bounded, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `CSLT_ASSERT_IMPLY(a_push_fits,
        push.count != 2'd0,
        (count_reg + CNT_W'(push.count)) <= CNT_W'(FIFO_DEPTH))
    `CSLT_ASSERT_NEXT(a_pop_only_drains,
        pop && (push.count == 2'd0),
        count_reg == $past(count_reg) - CNT_W'(1))

endmodule

// ----- rtl/c_style_lexical_tokenizer.sv -----
// a beat waits in the input register until the queue has room, then is lexed into the queue
// throughput: one text byte per cycle while the queue has room; a byte that closes a token
//   and is itself an operator gives two results, which leave in order through the four-entry queue
// reset: rst_n asynchronous active low; lexer returns to idle at offset 0, queue empties
// top level: input register + lexer state machine, then the result queue
`timescale 1ns / 1ps

module c_style_lexical_tokenizer
    import cslt_pkg::*;
#(
    // tokens longer than this, clamped to 1..127, report the cap and set length_overflow
    parameter int TOKEN_LIMIT = CSLT_TOKEN_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,

    // text channel: one source byte or an end-of-text marker per beat
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,

    // token channel: one reported token per beat
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       token_kind,
    output logic [LEN_W-1:0] token_length,
    output logic             length_overflow,
    output logic [POS_W-1:0] start_offset,
    output logic [7:0]       operator_char,
    output logic             last_of_run
);

    cslt_push_t   push;
    cslt_result_t head;
    logic         room;

    // lexer holds the byte in its input register until the queue can take
    // both results that the byte might produce; only then does the mode,
    // run length, run start and byte position advance
    cslt_lexer #(
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .room        (room),
        .push        (push)
    );

    // result queue parts the text side from the token side, so a stalled
    // consumer stops the next byte only once fewer than two queue entries are free
    cslt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // head of the queue drives the token ports directly
    assign token_kind      = head.kind;
    assign token_length    = head.length;
    assign length_overflow = head.overflow;
    assign start_offset    = head.start;
    assign operator_char   = head.opch;
    assign last_of_run     = head.last;

endmodule

// ----- tb/sv/c_style_lexical_tokenizer_tb.sv -----
// self-checking bench for the streaming c-style tokenizer: byte stimulus, token prediction
// and in-order comparison of every reported token
// depends on cslt_pkg and the c_style_lexical_tokenizer rtl
`timescale 1ns / 1ps

module c_style_lexical_tokenizer_tb;
    import cslt_pkg::*;

    // length cap as the block applies it, clamped to what token_length can hold
    localparam int LEN_CAP = (CSLT_TOKEN_LIMIT > 127) ? 127 :
                             (CSLT_TOKEN_LIMIT < 1) ? 1 : CSLT_TOKEN_LIMIT;

    localparam logic [7:0] OPERATORS [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                             CH_EQ, CH_LT, CH_GT, CH_PCT};

    // per-phase idle chances in percent: none, sender only, receiver only, both
    localparam int PHASE_SEND_IDLE [4] = '{0, 50, 0, 19};
    localparam int PHASE_RECV_STALL [4] = '{0, 0, 50, 19};
    localparam int BEATS_PER_PHASE = 330;

    // cycles allowed for the block to settle after the last expected token
    localparam int SETTLE_CYCLES = 16;

    // tracks the lexer state, predicts the tokens each text beat causes and checks them
    class token_scoreboard;
        cslt_mode_t          mode;
        logic [LEN_W-1:0]    run_len;
        logic                run_ovf;
        logic [POS_W-1:0]    run_start;
        logic [POS_W-1:0]    offset;
        cslt_result_t        step_tokens[$];
        cslt_result_t        expected_tokens[$];
        int                  mismatches;

        function new();
            mismatches = 0;
            restart_text();
        endfunction

        function void restart_text();
            mode      = MODE_IDLE;
            run_len   = '0;
            run_ovf   = 1'b0;
            run_start = '0;
            offset    = '0;
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        function bit word_start(input logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
        endfunction

        function bit digit(input logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit operator_byte(input logic [7:0] c);
            case (c)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_LT, CH_GT, CH_PCT: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void add_token(input cslt_kind_t k, input logic [LEN_W-1:0] len,
                                input logic ovf, input logic [POS_W-1:0] st,
                                input logic [7:0] oc);
            cslt_result_t r;
            r.kind     = k;
            r.length   = len;
            r.overflow = ovf;
            r.start    = st;
            r.opch     = oc;
            r.last     = 1'b0;
            step_tokens.push_back(r);
        endfunction

        function void close_open();
            case (mode)
                MODE_IDENT: add_token(KIND_IDENT, run_len, run_ovf, run_start, 8'h00);
                MODE_CONST: add_token(KIND_CONST, run_len, run_ovf, run_start, 8'h00);
                MODE_SLASH: add_token(KIND_OPER, 7'd1, 1'b0, run_start, CH_SLASH);
                default: ;
            endcase
        endfunction

        function void open_run(input cslt_mode_t m, input logic [POS_W-1:0] p);
            mode      = m;
            run_len   = 7'd1;
            run_ovf   = 1'b0;
            run_start = p;
        endfunction

        function void start_fresh(input logic [7:0] c, input logic [POS_W-1:0] p);
            mode = MODE_IDLE;
            if (c == CH_SLASH) begin
                mode      = MODE_SLASH;
                run_start = p;
            end
            else if (word_start(c))
                open_run(MODE_IDENT, p);
            else if (digit(c))
                open_run(MODE_CONST, p);
            else if (operator_byte(c))
                add_token(KIND_OPER, 7'd1, 1'b0, p, c);
        endfunction

        function void extend_run();
            if (run_len < LEN_CAP)
                run_len = run_len + 1'b1;
            else
                run_ovf = 1'b1;
        endfunction

        // predict the tokens caused by one accepted text beat
        function void note_byte(input logic [7:0] c, input logic eot);
            cslt_result_t r;
            int n;
            if (eot) begin
                close_open();
                restart_text();
            end
            else begin
                case (mode)
                    MODE_IDENT:
                        if (word_start(c) || digit(c))
                            extend_run();
                        else
                        begin
                            close_open();
                            start_fresh(c, offset);
                        end
                    MODE_CONST:
                        if (digit(c))
                            extend_run();
                        else
                        begin
                            close_open();
                            start_fresh(c, offset);
                        end
                    MODE_SLASH:
                        if (c == CH_SLASH)
                            mode = MODE_LINE;
                        else if (c == CH_STAR)
                            mode = MODE_BLOCK;
                        else
                        begin
                            close_open();
                            start_fresh(c, offset);
                        end
                    MODE_LINE:
                        if (c == CH_LF)
                            mode = MODE_IDLE;
                    MODE_BLOCK:
                        if (c == CH_STAR)
                            mode = MODE_BSTAR;
                    MODE_BSTAR:
                        if (c == CH_SLASH)
                            mode = MODE_IDLE;
                        else if (c != CH_STAR)
                            mode = MODE_BLOCK;
                    default:
                        start_fresh(c, offset);
                endcase
                offset = offset + 1'b1;
            end
            n = step_tokens.size();
            for (int i = 0; i < n; i++)
            begin
                r      = step_tokens[i];
                r.last = (i == n - 1);
                expected_tokens.push_back(r);
            end
            step_tokens.delete();
        endfunction

        // compare one accepted token beat with the oldest prediction
        task check_token(input logic [1:0] kind, input logic [LEN_W-1:0] len,
                         input logic ovf, input logic [POS_W-1:0] st,
                         input logic [7:0] oc, input logic last);
            cslt_result_t e;
            if (expected_tokens.size() == 0) begin
                flag_mismatch($sformatf("token kind %0d at offset %0d with none expected",
                                        kind, st));
            end
            else
            begin
                e = expected_tokens.pop_front();
                if (kind !== e.kind)
                    flag_mismatch($sformatf("token_kind %0d, expected %0d", kind, e.kind));
                if (len !== e.length)
                    flag_mismatch($sformatf("token_length %0d, expected %0d", len, e.length));
                if (ovf !== e.overflow)
                    flag_mismatch($sformatf("length_overflow %0b, expected %0b", ovf,
                                            e.overflow));
                if (st !== e.start)
                    flag_mismatch($sformatf("start_offset %0d, expected %0d", st, e.start));
                if (oc !== e.opch)
                    flag_mismatch($sformatf("operator_char %h, expected %h", oc, e.opch));
                if (last !== e.last)
                    flag_mismatch($sformatf("last_of_run %0b, expected %0b", last, e.last));
            end
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       text_byte;
    logic             end_of_text;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       token_kind;
    logic [LEN_W-1:0] token_length;
    logic             length_overflow;
    logic [POS_W-1:0] start_offset;
    logic [7:0]       operator_char;
    logic             last_of_run;

    token_scoreboard  token_check;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               beats_sent = 0;

    c_style_lexical_tokenizer #(
        .TOKEN_LIMIT (CSLT_TOKEN_LIMIT)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .token_kind      (token_kind),
        .token_length    (token_length),
        .length_overflow (length_overflow),
        .start_offset    (start_offset),
        .operator_char   (operator_char),
        .last_of_run     (last_of_run)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver backpressure, redrawn every cycle at the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both channels are observed at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            token_check.note_byte(text_byte, end_of_text);
        if (rst_n && out_valid && out_ready)
            token_check.check_token(token_kind, token_length, length_overflow,
                                    start_offset, operator_char, last_of_run);
    end

    // offer one text beat, starting and ending at a falling edge; valid holds until accepted
    task automatic send_beat(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // hold the sender off until every predicted token has come out
    task automatic wait_for_tokens();
        in_valid <= 1'b0;
        while (token_check.expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    // letters and underscore anywhere in a word, digits only after the first character
    function automatic logic [7:0] pick_word_char(input bit first);
        int r;
        r = $urandom_range(first ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    // one random piece of source text: mostly well-formed tokens and comments,
    // plus noise bytes, stray slashes and texts cut off inside a comment
    task automatic send_fragment();
        int sel;
        int len;
        logic [7:0] c;
        sel = $urandom_range(99);
        // long runs now and then so the length cap and its overflow flag get hit
        len = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 1);
        if (sel < 25) begin
            send_beat(pick_word_char(1'b1), 1'b0);
            repeat (len - 1)
                send_beat(pick_word_char(1'b0), 1'b0);
        end
        else if (sel < 40) begin
            repeat (len)
                send_beat(8'("0" + $urandom_range(9)), 1'b0);
        end
        else if (sel < 55) begin
            send_beat(OPERATORS[$urandom_range(7)], 1'b0);
        end
        else if (sel < 65) begin
            c = 8'($urandom_range(6));
            send_beat((c == 8'd6) ? 8'h20 : 8'h09 + c, 1'b0);
        end
        else if (sel < 72) begin
            send_text("//");
            repeat ($urandom_range(6))
            begin
                c = 8'($urandom_range(255));
                send_beat((c == CH_LF) ? 8'h20 : c, 1'b0);
            end
            send_beat(CH_LF, 1'b0);
        end
        else if (sel < 80) begin
            // stars and slashes are frequent inside so near-closers show up
            send_text("/*");
            repeat ($urandom_range(8))
            begin
                if ($urandom_range(2) == 0)
                    send_beat($urandom_range(1) ? CH_STAR : CH_SLASH, 1'b0);
                else
                    send_beat(8'($urandom_range(255)), 1'b0);
            end
            send_text("*/");
        end
        else if (sel < 85) begin
            send_beat(CH_SLASH, 1'b0);
            send_beat(8'($urandom_range(255)), 1'b0);
        end
        else if (sel < 93) begin
            send_beat(8'($urandom_range(255)), 1'b0);
        end
        else if (sel < 96) begin
            send_beat(8'($urandom_range(255)), 1'b1);
        end
        else
        begin
            send_text($urandom_range(1) ? "/*" : "//");
            repeat ($urandom_range(3))
                send_beat(8'($urandom_range(255)), 1'b0);
            send_beat(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // stimulus and final verdict
    initial
    begin
        int phase_first;
        in_valid    = 1'b0;
        text_byte   = 8'h00;
        end_of_text = 1'b0;
        rst_n       = 1'b0;
        token_check = new();
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed text:
        // identifier closed by an operator (two tokens from one beat), constant closed by
        // a held slash, held slash flushed by an operator (two tokens again), every other
        // operator, skipped nul and high bytes, line comment holding a high byte,
        // block comment whose slash-star-slash does not close it, slash flushed at the end
        send_text("_Zz09+90/-*=<>%");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("//");
        send_beat(8'hFF, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_text("/*/**/");
        send_text("/");
        send_beat(8'h00, 1'b1);
        wait_for_tokens();

        // random text under each idling mix, draining between mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = PHASE_SEND_IDLE[ph];
            recv_stall_pct = PHASE_RECV_STALL[ph];
            phase_first    = beats_sent;
            while (beats_sent - phase_first < BEATS_PER_PHASE)
                send_fragment();
            wait_for_tokens();
        end

        // close whatever is still open, then let the pipeline settle
        send_beat(8'h00, 1'b1);
        wait_for_tokens();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (token_check.expected_tokens.size() != 0)
            token_check.flag_mismatch($sformatf("%0d expected tokens never came out",
                                                token_check.expected_tokens.size()));

        if (token_check.mismatches == 0)
            $display("c_style_lexical_tokenizer_tb OK");
        else
            $display("c_style_lexical_tokenizer_tb NOT OK");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("c_style_lexical_tokenizer_tb NOT OK");
        $finish;
    end

endmodule
